[design/shq_pkg.sv]
`timescale 1ns / 1ps
package shq_pkg;

  // table geometry
  localparam int BUCKETS = 256;
  localparam int DEPTH   = 32;
  localparam int BKT_W   = 8;
  localparam int SLOT_W  = 5;
  localparam int FILL_W  = 6;
  localparam int ADDR_W  = BKT_W + SLOT_W;
  localparam int SLOTS   = BUCKETS * DEPTH;

  // iteration counts of the serial divider and remainder units
  localparam int DIV_STEPS = 17;
  localparam int MOD_STEPS = 32;
  localparam int CNT_W     = 5;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  // request kinds
  localparam logic [1:0] REQ_CLEAR       = 2'd0;
  localparam logic [1:0] REQ_INSERT      = 2'd1;
  localparam logic [1:0] REQ_QUERY_LOWER = 2'd2;
  localparam logic [1:0] REQ_QUERY_ALL   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NEG  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_NUM_BUCKETS = 2'd0;
  localparam logic [1:0] CFG_CELL_EDGE   = 2'd1;
  localparam logic [1:0] CFG_RADIUS_SQ   = 2'd2;

  typedef enum logic [1:0] {
    OUT_ACK,
    OUT_OWN,
    OUT_PEND
  } out_kind_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              div_init;
    logic              div_step;
    logic              mul_step;
    logic [1:0]        mul_lane;
    logic              mod_init;
    logic              mod_step;
    logic              fill_rd;
    logic              ins_wr;
    logic              ent_rd;
    logic [SLOT_W-1:0] slot;
    logic              dist_diff;
    logic              dist_sq;
    logic              pend_set;
    logic              out_load;
    out_kind_t         out_kind;
    logic [1:0]        out_status;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic              neg_hash;
    logic [FILL_W-1:0] fill;
    logic              match;
    logic              has_pend;
    logic              out_free;
  } status_t;

  function automatic logic [31:0] prime_of(input logic [1:0] lane);
    logic [31:0] p;
    unique case (lane)
      2'd0:    p = PRIME_X;
      2'd1:    p = PRIME_Y;
      default: p = PRIME_Z;
    endcase
    return p;
  endfunction

endpackage

[design/shq_ctrl.sv]
`timescale 1ns / 1ps
module shq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [1:0]      s_req,
  input  shq_pkg::status_t sts,
  output shq_pkg::cmd_t   cmd
);
  import shq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_MUL,
    S_MOD_INIT,
    S_MOD,
    S_HASH,
    S_FILL_RD,
    S_FILL_OK,
    S_WALK,
    S_DIFF,
    S_SQ,
    S_CMP,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t          state;
  logic [CNT_W-1:0] cnt;
  logic [FILL_W-1:0] slot;
  logic [1:0]      req;
  out_kind_t       emit_kind;
  logic [1:0]      emit_status;

  logic full;
  logic walk_done;

  assign full      = sts.fill >= FILL_W'(DEPTH);
  assign walk_done = slot == sts.fill;
  assign s_tready  = state == S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      slot        <= '0;
      req         <= REQ_CLEAR;
      emit_kind   <= OUT_ACK;
      emit_status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (s_tvalid) begin
            req <= s_req;
            if (s_req == REQ_CLEAR) begin
              emit_kind   <= OUT_ACK;
              emit_status <= ST_OK;
              state       <= S_EMIT;
            end else begin
              state <= S_DIV_INIT;
            end
          end
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(2)) begin
            state <= S_MOD_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOD_INIT: begin
          cnt   <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          if (cnt == CNT_W'(MOD_STEPS - 1)) begin
            state <= S_HASH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_HASH: begin
          if (sts.neg_hash) begin
            emit_kind   <= (req == REQ_INSERT) ? OUT_ACK : OUT_OWN;
            emit_status <= ST_NEG;
            state       <= S_EMIT;
          end else begin
            state <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_OK;
        end
        S_FILL_OK: begin
          slot <= '0;
          if (req == REQ_INSERT) begin
            emit_kind   <= OUT_ACK;
            emit_status <= full ? ST_FULL : ST_OK;
            state       <= S_EMIT;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          state <= walk_done ? S_FLUSH : S_DIFF;
        end
        S_DIFF: begin
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!sts.match || !sts.has_pend || sts.out_free) begin
            slot  <= slot + 1'b1;
            state <= S_WALK;
          end
        end
        S_FLUSH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.out_kind   = OUT_ACK;
    cmd.out_status = ST_OK;
    cmd.mul_lane   = cnt[1:0];
    cmd.slot       = slot[SLOT_W-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.load  = s_tvalid;
        cmd.clear = s_tvalid && (s_req == REQ_CLEAR);
      end
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_MUL:      cmd.mul_step = 1'b1;
      S_MOD_INIT: cmd.mod_init = 1'b1;
      S_MOD:      cmd.mod_step = 1'b1;
      S_FILL_RD:  cmd.fill_rd  = 1'b1;
      S_FILL_OK:  cmd.ins_wr   = (req == REQ_INSERT) && !full;
      S_WALK:     cmd.ent_rd   = !walk_done;
      S_DIFF:     cmd.dist_diff = 1'b1;
      S_SQ:       cmd.dist_sq  = 1'b1;
      S_CMP: begin
        if (sts.match && (!sts.has_pend || sts.out_free)) begin
          cmd.pend_set = 1'b1;
          cmd.out_load = sts.has_pend;
          cmd.out_kind = OUT_PEND;
          cmd.out_last = 1'b0;
        end
      end
      S_FLUSH: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sts.has_pend ? OUT_PEND : OUT_ACK;
        cmd.out_last = 1'b1;
      end
      S_EMIT: begin
        cmd.out_load   = sts.out_free;
        cmd.out_kind   = emit_kind;
        cmd.out_status = emit_status;
        cmd.out_last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[design/shq_dp.sv]
`timescale 1ns / 1ps
module shq_dp (
  input  logic               clk,
  input  logic               rst,
  input  shq_pkg::cmd_t      cmd,
  output shq_pkg::status_t   sts,
  input  logic [1:0]         s_req,
  input  logic [31:0]        s_pos_x,
  input  logic [31:0]        s_pos_y,
  input  logic [31:0]        s_pos_z,
  input  logic [15:0]        s_pid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_match_id,
  output logic               m_match_found,
  output logic [1:0]         m_status,
  output logic               m_last
);
  import shq_pkg::*;

  // configuration
  logic [8:0]  num_buckets;
  logic [15:0] cell_edge;
  logic [63:0] radius_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= 9'd251;
      cell_edge   <= 16'd10;
      radius_sq   <= 64'd42949673;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_BUCKETS: num_buckets <= cfg_data[8:0];
        CFG_CELL_EDGE:   cell_edge   <= cfg_data[15:0];
        CFG_RADIUS_SQ:   radius_sq   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] edge_eff;
  logic [8:0]  mod_eff;

  assign edge_eff = (cell_edge == 16'd0) ? 16'd1 : cell_edge;
  assign mod_eff  = (num_buckets == 9'd0) ? 9'd1 :
                    (num_buckets > 9'(BUCKETS)) ? 9'(BUCKETS) : num_buckets;

  // captured request
  logic [1:0]  req_q;
  logic [31:0] pos_q [3];
  logic [15:0] pid_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= s_req;
      pos_q[0] <= s_pos_x;
      pos_q[1] <= s_pos_y;
      pos_q[2] <= s_pos_z;
      pid_q    <= s_pid;
    end
  end

  // restoring dividers, one lane per axis, one quotient bit a cycle
  logic [16:0] dv_r     [3];
  logic [16:0] dv_q     [3];
  logic        dv_neg   [3];
  logic [16:0] dv_t     [3];
  logic [31:0] cell_idx [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_t[i]     = {dv_r[i][15:0], dv_q[i][16]};
      cell_idx[i] = dv_neg[i] ? (32'd0 - {15'd0, dv_q[i]}) : {15'd0, dv_q[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_init) begin
        dv_r[i]   <= '0;
        dv_neg[i] <= pos_q[i][31];
        dv_q[i]   <= pos_q[i][31] ? (17'd0 - {pos_q[i][31], pos_q[i][31:16]})
                                  : {1'b0, pos_q[i][31:16]};
      end else if (cmd.div_step) begin
        if (dv_t[i] >= {1'b0, edge_eff}) begin
          dv_r[i] <= dv_t[i] - {1'b0, edge_eff};
          dv_q[i] <= {dv_q[i][15:0], 1'b1};
        end else begin
          dv_r[i] <= dv_t[i];
          dv_q[i] <= {dv_q[i][15:0], 1'b0};
        end
      end
    end
  end

  // shared prime multiplier, one axis a cycle, xor folded
  logic [31:0] hash;
  logic [31:0] cell_sel;
  logic [31:0] prod;

  assign cell_sel = (cmd.mul_lane == 2'd0) ? cell_idx[0] :
                    (cmd.mul_lane == 2'd1) ? cell_idx[1] : cell_idx[2];
  assign prod     = cell_sel * prime_of(cmd.mul_lane);

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      hash <= ((cmd.mul_lane == 2'd0) ? 32'd0 : hash) ^ prod;
    end
  end

  // bit-serial remainder of the hash magnitude
  logic [31:0] md_s;
  logic [8:0]  md_r;
  logic [9:0]  md_t;

  assign md_t = {md_r, md_s[31]};

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      md_s <= hash[31] ? (32'd0 - hash) : hash;
      md_r <= '0;
    end else if (cmd.mod_step) begin
      md_s <= {md_s[30:0], 1'b0};
      if (md_t >= {1'b0, mod_eff}) begin
        md_r <= 9'(md_t - {1'b0, mod_eff});
      end else begin
        md_r <= md_t[8:0];
      end
    end
  end

  logic [BKT_W-1:0] bucket;
  assign bucket = md_r[BKT_W-1:0];

  // bucket fill memory with per-bucket valid bits
  logic [FILL_W-1:0] fill_mem [BUCKETS];
  logic [FILL_W-1:0] fill_rd_q;
  logic [BUCKETS-1:0] fvalid;
  logic              fvalid_q;
  logic [FILL_W-1:0] fill_cur;

  assign fill_cur = fvalid_q ? fill_rd_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      fill_mem[bucket] <= fill_cur + 1'b1;
    end
    if (cmd.fill_rd) begin
      fill_rd_q <= fill_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid   <= '0;
      fvalid_q <= 1'b0;
    end else begin
      if (cmd.clear) begin
        fvalid <= '0;
      end else if (cmd.ins_wr) begin
        fvalid[bucket] <= 1'b1;
      end
      if (cmd.fill_rd) begin
        fvalid_q <= fvalid[bucket];
      end
    end
  end

  // entry memory: x, y, z, id from the lowest bit up
  logic [111:0] ent_mem [SLOTS];
  logic [111:0] ent_q;

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      ent_mem[{bucket, fill_cur[SLOT_W-1:0]}] <= {pid_q, pos_q[2], pos_q[1], pos_q[0]};
    end
    if (cmd.ent_rd) begin
      ent_q <= ent_mem[{bucket, cmd.slot}];
    end
  end

  // distance: absolute differences, squares, saturated sum
  logic [31:0] ad [3];
  logic [63:0] sq [3];
  logic [32:0] df [3];
  logic [32:0] df_abs [3];
  logic [65:0] dsum;
  logic [63:0] dist_sat;
  logic [15:0] ent_id;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i]     = {pos_q[i][31], pos_q[i]} - {ent_q[32*i+31], ent_q[32*i +: 32]};
      df_abs[i] = df[i][32] ? (33'd0 - df[i]) : df[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.dist_diff) begin
        ad[i] <= df_abs[i][31:0];
      end
      if (cmd.dist_sq) begin
        sq[i] <= {32'd0, ad[i]} * {32'd0, ad[i]};
      end
    end
  end

  assign ent_id   = ent_q[111:96];
  assign dsum     = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
  assign dist_sat = (dsum[65:64] != 2'b0) ? {64{1'b1}} : dsum[63:0];

  // match held back one step so the final one can carry last
  logic        has_pend;
  logic [15:0] pend_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_pend <= 1'b0;
    end else if (cmd.load) begin
      has_pend <= 1'b0;
    end else if (cmd.pend_set) begin
      has_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_id <= ent_id;
    end
  end

  // output register
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_status <= cmd.out_status;
      m_last   <= cmd.out_last;
      unique case (cmd.out_kind)
        OUT_OWN: begin
          m_match_id    <= pid_q;
          m_match_found <= 1'b1;
        end
        OUT_PEND: begin
          m_match_id    <= pend_id;
          m_match_found <= 1'b1;
        end
        default: begin
          m_match_id    <= '0;
          m_match_found <= 1'b0;
        end
      endcase
    end
  end

  // status to the controller
  assign sts.neg_hash = hash[31] && (md_r != 9'd0);
  assign sts.fill     = fill_cur;
  assign sts.match    = (dist_sat < radius_sq) &&
                        ((req_q != REQ_QUERY_LOWER) || (ent_id < pid_q));
  assign sts.has_pend = has_pend;
  assign sts.out_free = out_free;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register loaded while a result is still waiting");

  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.pend_set && has_pend) |-> cmd.out_load)
    else $error("held match replaced without being sent");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> (fill_cur < FILL_W'(DEPTH)))
    else $error("insert into a full bucket");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

[design/spatial_hash_neighbor_query.sv]
`timescale 1ns / 1ps
// channel    dir  tdata (low bit up)                         tuser / tlast
// s_axis     in   pos_x, pos_y, pos_z, particle_id           tuser: req_type
// m_axis     out  match_id, match_found, status, 5 zero bits tlast: last
// cfg        in   cfg_data: register value, cfg_index: 0..2  write when cfg_we
//
// one item at a time; transfer, divider load, 17 restoring divider steps,
// 3 steps on the shared prime multiplier, remainder load, 32 remainder steps,
// then sign check, fill read and fill check; a negative hash, an insert or
// a clear (straight from the transfer) loads its result in the emit state;
// a query walks the stored entries (memory read, difference, square,
// compare), then an end-of-walk check and the flush; result loads wait for
// m_axis; rst is synchronous; fills clear at once via valid bits, no sweep
module spatial_hash_neighbor_query (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // pos_x, pos_y, pos_z, particle_id
  input  logic [1:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // match_id, match_found, status, zero pad
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import shq_pkg::*;

  cmd_t    cmd;
  status_t sts;

  logic [15:0] match_id;
  logic        match_found;
  logic [1:0]  status;

  assign m_axis_tdata = {5'd0, status, match_found, match_id};

  shq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_req    (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  shq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_req         (s_axis_tuser),
    .s_pos_x       (s_axis_tdata[31:0]),
    .s_pos_y       (s_axis_tdata[63:32]),
    .s_pos_z       (s_axis_tdata[95:64]),
    .s_pid         (s_axis_tdata[111:96]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_match_id    (match_id),
    .m_match_found (match_found),
    .m_status      (status),
    .m_last        (m_axis_tlast)
  );

endmodule
